// ----- rtl/ttm_pkg.sv -----
// ----------------------------------------------------------------------------
// ttm_pkg
// Shared types and constants of the text mode terminal: request and result
// beats, request codes, control characters and blank cell values.
// ----------------------------------------------------------------------------
package ttm_pkg;

    // default geometry
    localparam int DEF_COLS      = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    // cell layout: attribute high byte, character low byte
    localparam int CELL_W = 16;

    // request codes
    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } req_code_t;

    // character codes
    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

    // attribute after reset, also used by the power-on blanking pass
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    // request beat
    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } request_t;

    // result beat
    typedef struct packed {
        logic [10:0] cursor_location;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [15:0] read_cell;
        logic        scrolled;
    } result_t;

endpackage

// ----- rtl/text_mode_terminal.sv -----
// ----------------------------------------------------------------------------
// text_mode_terminal
// Character-cell text terminal with cursor, attribute register and a
// cell store walked by one sequencer for scroll and clear.
// ----------------------------------------------------------------------------
// put and read pass S_PUT or S_READ, then S_FINISH, and done is registered; busy
// drops with done, so the next request is accepted while done is high
// a put that scrolls adds a row copy then a blank row fill,
// a clear adds a fill of the whole store, one store write each cycle
// reset: blanks the store at attribute 0x0F with busy high
// results come as a one-cycle done strobe; the receiver cannot stall
module text_mode_terminal #(
    parameter int COLS      = ttm_pkg::DEF_COLS,
    parameter int ROWS      = ttm_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = ttm_pkg::DEF_TAB_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ttm_pkg::request_t request,
    output logic              done,
    output ttm_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    import ttm_pkg::*;

    localparam int AW = $clog2(COLS * ROWS);

    logic [7:0]    attr_reg;
    logic [7:0]    attr_next;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;

    // attribute register write beat
    assign cfg_ready = 1'b1;
    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    // request sequencer
    ttm_ctrl #(
        .COLS      (COLS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .attr    (attr_reg),
        .done    (done),
        .result  (result),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    // cell store
    ttm_ram #(
        .WIDTH (CELL_W),
        .DEPTH (COLS * ROWS)
    ) u_cells (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

`ifndef ASSERT_OFF
    // a result beat only ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request in flight");

    // an accepted request makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // a scroll leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cursor_row == 5'(ROWS - 1)))
        else $error("scroll left cursor off the last row");

    // cursor row stays on the screen
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.cursor_row) < ROWS))
        else $error("cursor row out of range");
`endif

endmodule

// ----- rtl/ttm_ram.sv -----
// ----------------------------------------------------------------------------
// ttm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ttm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ttm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttm_ctrl
// Request sequencer of the text terminal: cursor update, cell writes and the
// store walks for scroll, clear and power-on blanking, all through the single
// write port of the cell store.
// ----------------------------------------------------------------------------
module ttm_ctrl #(
    parameter int COLS      = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8,
    localparam int AW       = $clog2(COLS * ROWS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ttm_pkg::request_t request,
    input  logic [7:0]        attr,
    output logic              done,
    output ttm_pkg::result_t  result,
    output logic              we,
    output logic [AW-1:0]     waddr,
    output logic [15:0]       wdata,
    output logic [AW-1:0]     raddr,
    input  logic [15:0]       rdata
);

    import ttm_pkg::*;

    localparam int CELL_COUNT = COLS * ROWS;
    localparam int LAST_SRC   = (ROWS - 1) * COLS;
    localparam int CW         = $clog2(COLS + TAB_WIDTH + 1);
    localparam int LW         = $clog2(ROWS + 1);
    localparam int PW         = $clog2(TAB_WIDTH);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_FINISH
    } state_t;

    state_t            state_reg,   state_next;
    request_t          req_reg,     req_next;
    logic [CW-1:0]     col_reg,     col_next;
    logic [LW-1:0]     line_reg,    line_next;
    logic [PW-1:0]     phase_reg,   phase_next;
    logic [AW-1:0]     idx_reg,     idx_next;
    logic              pend_reg,    pend_next;
    logic [AW-1:0]     wr_idx_reg,  wr_idx_next;
    logic              scroll_reg,  scroll_next;
    logic              rd_ok_reg,   rd_ok_next;
    logic              done_reg,    done_next;
    result_t           result_reg,  result_next;

    logic [AW-1:0]     loc;
    logic [CW-1:0]     col_a;
    logic [LW-1:0]     line_a;
    logic [PW-1:0]     phase_a;
    logic              print_hit;

    // shared address unit: cursor cell address
    assign loc = AW'(line_reg) * AW'(COLS) + AW'(col_reg);

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // character handling before the column wrap
    always_comb
    begin
        col_a     = col_reg;
        line_a    = line_reg;
        phase_a   = phase_reg;
        print_hit = 1'b0;
        case (req_reg.char_code) inside
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_a   = col_reg - CW'(1);
                    phase_a = (phase_reg == '0) ? PW'(TAB_WIDTH - 1) : phase_reg - PW'(1);
                end
            end
            CH_TAB:
            begin
                col_a   = col_reg + CW'(TAB_WIDTH) - CW'(phase_reg);
                phase_a = '0;
            end
            CH_CR:
            begin
                col_a   = '0;
                phase_a = '0;
            end
            CH_LF:
            begin
                col_a   = '0;
                phase_a = '0;
                line_a  = line_reg + LW'(1);
            end
            [CH_SPACE:CH_LAST_PRINT]:
            begin
                print_hit = 1'b1;
                col_a     = col_reg + CW'(1);
                phase_a   = (phase_reg == PW'(TAB_WIDTH - 1)) ? '0 : phase_reg + PW'(1);
            end
            default:
            begin
                col_a = col_reg;
            end
        endcase
    end

    // store port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = {attr, CH_SPACE};
        raddr = AW'(request.cell_index);
        if (pend_reg)
        begin
            we    = 1'b1;
            waddr = wr_idx_reg;
            wdata = rdata;
        end
        else if (state_reg == S_INIT)
        begin
            we    = 1'b1;
            wdata = {RESET_ATTR, CH_SPACE};
        end
        else if (state_reg == S_FILL)
        begin
            we = 1'b1;
        end
        else if (state_reg == S_PUT && print_hit)
        begin
            we    = 1'b1;
            waddr = loc;
            wdata = {attr, req_reg.char_code};
        end
        if (state_reg == S_SCROLL)
        begin
            raddr = idx_reg + AW'(COLS);
        end
        else if (state_reg == S_READ)
        begin
            raddr = AW'(req_reg.cell_index);
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        col_next    = col_reg;
        line_next   = line_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        wr_idx_next = wr_idx_reg;
        scroll_next = scroll_reg;
        rd_ok_next  = rd_ok_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_INIT:
            begin
                if (idx_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request;
                    scroll_next = 1'b0;
                    rd_ok_next  = 1'b0;
                    case (request.req_type)
                        REQ_PUT:
                        begin
                            state_next = S_PUT;
                        end
                        REQ_CLEAR:
                        begin
                            col_next   = '0;
                            line_next  = '0;
                            phase_next = '0;
                            idx_next   = '0;
                            state_next = S_FILL;
                        end
                        REQ_READ:
                        begin
                            rd_ok_next = (32'(request.cell_index) < CELL_COUNT);
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                col_next   = col_a;
                line_next  = line_a;
                phase_next = phase_a;
                if (col_a >= CW'(COLS))
                begin
                    col_next   = '0;
                    phase_next = '0;
                    line_next  = line_a + LW'(1);
                end
                if (line_next == LW'(ROWS))
                begin
                    line_next   = LW'(ROWS - 1);
                    scroll_next = 1'b1;
                    idx_next    = '0;
                    state_next  = S_SCROLL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                state_next = S_FINISH;
            end
            S_SCROLL:
            begin
                // read one row down, write back on the next cycle
                if (idx_reg < AW'(LAST_SRC))
                begin
                    pend_next   = 1'b1;
                    wr_idx_next = idx_reg;
                    idx_next    = idx_reg + AW'(1);
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (idx_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_FINISH:
            begin
                result_next.cursor_location = 11'(loc);
                result_next.cursor_col      = 7'(col_reg);
                result_next.cursor_row      = 5'(line_reg);
                result_next.read_cell       = rd_ok_reg ? rdata : 16'h0000;
                result_next.scrolled        = scroll_reg;
                done_next                   = 1'b1;
                state_next                  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            col_reg    <= '0;
            line_reg   <= '0;
            phase_reg  <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            scroll_reg <= 1'b0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            line_reg   <= line_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            scroll_reg <= scroll_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        wr_idx_reg <= wr_idx_next;
        result_reg <= result_next;
    end

endmodule

// ----- sim/text_mode_terminal_tb.sv -----
// ----------------------------------------------------------------------------
// text_mode_terminal_tb
// Self-checking bench for the text mode terminal. A behavioral copy of the
// screen store, cursor and attribute register tracks every accepted request
// and predicts its result beat. Results are compared field by field in
// order. Stimulus is a short directed pass followed by random text lines
// with reads, clears and noise, over several attribute settings.
// ----------------------------------------------------------------------------
module text_mode_terminal_tb;
    import ttm_pkg::*;

    localparam int COLS      = DEF_COLS;
    localparam int ROWS      = DEF_ROWS;
    localparam int TAB_WIDTH = DEF_TAB_WIDTH;
    localparam int CELLS     = COLS * ROWS;

    // request code with no function in the block
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int DRAIN_LIMIT     = 3 * CELLS;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRINT_CAP       = 200;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [7:0] cfg_data;

    int cycle_count;

    // screen model and in-order store of predicted result beats
    class screen_scoreboard;
        logic [15:0] cells [CELLS];
        int          col;
        int          row;
        logic [7:0]  attr;
        result_t     expected_results [$];
        int          mismatch_count;

        function new();
            fill_blank(0, RESET_ATTR);
            col            = 0;
            row            = 0;
            attr           = RESET_ATTR;
            mismatch_count = 0;
        endfunction

        function void fill_blank(int first, logic [7:0] a);
            for (int i = first; i < CELLS; i++)
            begin
                cells[i] = {a, CH_SPACE};
            end
        endfunction

        // one byte at the cursor, returns 1 when the screen scrolled
        function bit put_char(logic [7:0] c);
            if (c == CH_BS)
            begin
                if (col > 0)
                    col--;
            end
            else if (c == CH_TAB)
                col = col + TAB_WIDTH - (col % TAB_WIDTH);
            else if (c == CH_CR)
                col = 0;
            else if (c == CH_LF)
            begin
                col = 0;
                row++;
            end
            else if (c >= CH_SPACE && c <= CH_LAST_PRINT)
            begin
                if (row * COLS + col < CELLS)
                    cells[row * COLS + col] = {attr, c};
                col++;
            end
            // wrap past the last column
            if (col >= COLS)
            begin
                col = 0;
                row++;
            end
            if (row < ROWS)
                return 1'b0;
            // scroll up one row and blank the bottom row
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
            begin
                cells[i] = cells[i + COLS];
            end
            fill_blank((ROWS - 1) * COLS, attr);
            row = ROWS - 1;
            return 1'b1;
        endfunction

        function void note_request(request_t rq);
            result_t predicted;
            predicted = '0;
            case (rq.req_type)
                REQ_PUT:
                    predicted.scrolled = put_char(rq.char_code);
                REQ_CLEAR:
                begin
                    fill_blank(0, attr);
                    col = 0;
                    row = 0;
                end
                REQ_READ:
                begin
                    if (rq.cell_index < CELLS)
                        predicted.read_cell = cells[rq.cell_index];
                end
                default:
                    ;
            endcase
            predicted.cursor_location = 11'(row * COLS + col);
            predicted.cursor_col      = 7'(col);
            predicted.cursor_row      = 5'(row);
            expected_results.push_back(predicted);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            // keep the log bounded when the block is badly broken
            if (mismatch_count < PRINT_CAP)
                $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
            mismatch_count++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result beat with no request pending", 16'(got), 16'h0);
                return;
            end
            want = expected_results.pop_front();
            if (got.cursor_location !== want.cursor_location)
                report_mismatch("cursor_location", 16'(got.cursor_location),
                                16'(want.cursor_location));
            if (got.cursor_col !== want.cursor_col)
                report_mismatch("cursor_col", 16'(got.cursor_col), 16'(want.cursor_col));
            if (got.cursor_row !== want.cursor_row)
                report_mismatch("cursor_row", 16'(got.cursor_row), 16'(want.cursor_row));
            if (got.read_cell !== want.read_cell)
                report_mismatch("read_cell", got.read_cell, want.read_cell);
            if (got.scrolled !== want.scrolled)
                report_mismatch("scrolled", 16'(got.scrolled), 16'(want.scrolled));
        endtask
    endclass

    screen_scoreboard sb;

    text_mode_terminal u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic request_t make_put(logic [7:0] c);
        request_t rq;
        rq.req_type   = REQ_PUT;
        rq.char_code  = c;
        rq.cell_index = 11'($urandom_range(0, 2047));
        return rq;
    endfunction

    function automatic request_t make_read(logic [10:0] idx);
        request_t rq;
        rq.req_type   = REQ_READ;
        rq.char_code  = 8'($urandom_range(0, 255));
        rq.cell_index = idx;
        return rq;
    endfunction

    // clear or unused code, other fields random
    function automatic request_t make_other(logic [1:0] kind);
        request_t rq;
        rq.req_type   = kind;
        rq.char_code  = 8'($urandom_range(0, 255));
        rq.cell_index = 11'($urandom_range(0, 2047));
        return rq;
    endfunction

    function automatic int pick_gap(bit idling);
        if (idling && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    // mostly printable, some cursor controls and ignored bytes
    function automatic logic [7:0] random_line_char();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 84)
            return 8'($urandom_range(CH_SPACE, CH_LAST_PRINT));
        if (pick < 89)
            return CH_TAB;
        if (pick < 92)
            return CH_BS;
        if (pick < 94)
            return CH_CR;
        if (pick < 97)
            return 8'($urandom_range(8'h80, 8'hFF));
        do
            c = 8'($urandom_range(0, CH_SPACE - 1));
        while (c inside {CH_BS, CH_TAB, CH_LF, CH_CR});
        return c;
    endfunction

    // reads mostly around the cursor row, some anywhere, some past the end
    function automatic logic [10:0] pick_cell_index();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 11'(sb.row * COLS + $urandom_range(0, COLS - 1));
        if (pick < 60)
            return 11'((sb.row > 0 ? sb.row - 1 : ROWS - 1) * COLS
                       + $urandom_range(0, COLS - 1));
        if (pick < 85)
            return 11'($urandom_range(0, CELLS - 1));
        return 11'($urandom_range(CELLS, 2047));
    endfunction

    // blank lines, short and medium lines, a few that wrap
    function automatic int pick_line_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 80)
            return $urandom_range(1, 12);
        if (pick < 95)
            return $urandom_range(13, COLS - 1);
        return $urandom_range(COLS, 2 * COLS + 10);
    endfunction

    // one request beat; start stays high after acceptance
    task automatic send_request(request_t rq, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(rq);
    endtask

    // attribute write once every pending result has come back
    task automatic write_attribute(logic [7:0] value);
        start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.attr = value;
    endtask

    // random text lines with reads, clears and noise between them
    task automatic run_phase(bit idling);
        int         counted;
        int         len;
        int         pick;
        logic [7:0] c;
        counted = 0;
        // sometimes start near the bottom so scrolling shows up early
        if ($urandom_range(0, 1) == 1)
        begin
            repeat ($urandom_range(0, ROWS - 1))
            begin
                send_request(make_put(CH_LF), pick_gap(idling));
                counted++;
            end
        end
        while (counted < ITEMS_PER_PHASE)
        begin
            len = pick_line_length();
            for (int i = 0; i < len; i++)
            begin
                c = random_line_char();
                send_request(make_put(c), pick_gap(idling));
                counted++;
            end
            // line ending
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                if (pick == 6)
                begin
                    send_request(make_put(CH_CR), pick_gap(idling));
                    counted++;
                end
                send_request(make_put(CH_LF), pick_gap(idling));
                counted++;
            end
            else if (pick == 9)
            begin
                send_request(make_put(CH_CR), pick_gap(idling));
                counted++;
            end
            // a few reads between lines
            repeat ($urandom_range(0, 3))
            begin
                send_request(make_read(pick_cell_index()), pick_gap(idling));
                counted++;
            end
            pick = $urandom_range(0, 59);
            if (pick == 0)
            begin
                send_request(make_other(REQ_CLEAR), pick_gap(idling));
                counted++;
            end
            else if (pick == 1)
            begin
                send_request(make_other(REQ_UNUSED), pick_gap(idling));
                counted++;
            end
        end
    endtask

    initial
    begin
        int drain;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        cycle_count = 0;
        sb          = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: store after reset, edges of the read index
        send_request(make_read(11'd0), 0);
        send_request(make_read(11'(CELLS - 1)), 0);
        send_request(make_read(11'(CELLS)), 0);
        send_request(make_read(11'h7FF), 3);
        // printable bytes including DEL
        send_request(make_put(8'h41), 0);
        send_request(make_put(CH_LAST_PRINT), 0);
        send_request(make_put(CH_SPACE), 5);
        // backspace, return, backspace at column zero, tabs
        send_request(make_put(CH_BS), 0);
        send_request(make_put(CH_CR), 0);
        send_request(make_put(CH_BS), 0);
        send_request(make_put(CH_TAB), 0);
        send_request(make_put(CH_TAB), 1);
        // ignored control and high bytes
        send_request(make_put(8'h00), 0);
        send_request(make_put(8'h1F), 0);
        send_request(make_put(8'h80), 0);
        send_request(make_put(8'hFF), 0);
        send_request(make_put(CH_LF), 0);
        send_request(make_other(REQ_UNUSED), 0);
        send_request(make_read(11'd0), 0);
        send_request(make_read(11'd1), 0);
        // clear with a non-reset attribute
        write_attribute(8'h5A);
        send_request(make_other(REQ_CLEAR), 0);
        send_request(make_read(11'd0), 0);
        send_request(make_read(11'(CELLS - 1)), 0);

        // random phases over several attributes, extremes first
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                write_attribute(8'h00);
            else if (p == 1)
                write_attribute(8'hFF);
            else
                write_attribute(8'($urandom_range(0, 255)));
            run_phase(p != PHASES - 1);
        end

        // drain outstanding results
        start <= 1'b0;
        drain = 0;
        while (sb.expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (sb.expected_results.size() != 0)
            sb.report_mismatch("results never returned", 16'(sb.expected_results.size()), 16'h0);
        repeat (10) @(posedge clk);

        if (sb.mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
